// ----- hdl/base64_stream_decoder_top_defines.svh -----
// Assertion macros used by the checker of the base64 stream decoder.
`ifndef BASE64_STREAM_DECODER_TOP_DEFINES_SVH
`define BASE64_STREAM_DECODER_TOP_DEFINES_SVH

// Same-cycle implication, sampled on clk, off while rst_n is low.
`define B64D_ASSERT_NOW(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("base64 decoder check failed");

// Next-cycle implication, sampled on clk, off while rst_n is low.
`define B64D_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("base64 decoder check failed");

`endif

// ----- hdl/b64d_pkg.sv -----
package b64d_pkg;

  typedef enum logic [1:0] {
    KIND_NONE  = 2'd0,
    KIND_BADCH = 2'd1,
    KIND_PAD   = 2'd2,
    KIND_LEN   = 2'd3
  } err_kind_t;

  localparam logic [7:0] CH_PLUS  = 8'h2B;
  localparam logic [7:0] CH_SLASH = 8'h2F;
  localparam logic [7:0] CH_PAD   = 8'h3D;
  localparam logic [7:0] CH_UA    = 8'h41;
  localparam logic [7:0] CH_UZ    = 8'h5A;
  localparam logic [7:0] CH_LA    = 8'h61;
  localparam logic [7:0] CH_LZ    = 8'h7A;
  localparam logic [7:0] CH_D0    = 8'h30;
  localparam logic [7:0] CH_D9    = 8'h39;

  localparam logic [1:0] POS_LAST = 2'd3;

  localparam int QDEPTH = 4;
  localparam int QAW    = $clog2(QDEPTH);
  localparam int QCW    = $clog2(QDEPTH + 1);

  typedef struct packed {
    logic       bad;
    logic       pad;
    logic [5:0] sext;
  } char_class_t;

  // One decoded group or one error report, handed from front to back.
  typedef struct packed {
    logic [23:0] data;
    logic [1:0]  nbytes;
    logic        last;
    logic        err;
    err_kind_t   kind;
  } job_t;

  function automatic char_class_t classify(input logic [7:0] c);
    char_class_t r;
    logic [7:0]  d;
    r.bad  = 1'b0;
    r.pad  = 1'b0;
    r.sext = 6'd0;
    d      = 8'd0;
    if (c >= CH_UA && c <= CH_UZ) begin
      d = c - CH_UA;
    end else if (c >= CH_LA && c <= CH_LZ) begin
      d = c - CH_LA + 8'd26;
    end else if (c >= CH_D0 && c <= CH_D9) begin
      d = c - CH_D0 + 8'd52;
    end else if (c == CH_PLUS) begin
      d = 8'd62;
    end else if (c == CH_SLASH) begin
      d = 8'd63;
    end else if (c == CH_PAD) begin
      r.pad = 1'b1;
    end else begin
      r.bad = 1'b1;
    end
    r.sext = d[5:0];
    return r;
  endfunction

endpackage

// ----- hdl/b64d_front.sv -----
module b64d_front (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            in_valid,
  output logic            in_ready,
  input  logic [7:0]      in_char,
  input  logic            in_last,
  input  logic            q_full,
  output logic            q_push,
  output b64d_pkg::job_t  q_job
);

  logic [1:0]  pos_r, pos_nxt;
  logic [17:0] accum_r, accum_nxt;
  logic [1:0]  pads_r, pads_nxt;
  logic        disc_r, disc_nxt;

  b64d_pkg::char_class_t cls;
  b64d_pkg::err_kind_t   kind;
  logic                  fail;
  logic                  accept;
  logic [1:0]            pads_sum;

  assign in_ready = !q_full;
  assign accept   = in_valid && in_ready;
  assign cls      = b64d_pkg::classify(in_char);
  assign pads_sum = pads_r + {1'b0, cls.pad};

  always_comb begin
    fail = 1'b1;
    kind = b64d_pkg::KIND_NONE;
    if (in_last && pos_r != b64d_pkg::POS_LAST) begin
      kind = b64d_pkg::KIND_LEN;
    end else if (cls.bad) begin
      kind = b64d_pkg::KIND_BADCH;
    end else if (cls.pad && (pos_r[1] == 1'b0 ||
                 (pos_r == b64d_pkg::POS_LAST && !in_last))) begin
      kind = b64d_pkg::KIND_PAD;
    end else if (!cls.pad && pos_r == b64d_pkg::POS_LAST && pads_r != 2'd0) begin
      kind = b64d_pkg::KIND_PAD;
    end else begin
      fail = 1'b0;
    end
  end

  always_comb begin
    pos_nxt   = pos_r;
    accum_nxt = accum_r;
    pads_nxt  = pads_r;
    disc_nxt  = disc_r;
    q_push    = 1'b0;
    q_job     = '0;
    if (accept) begin
      if (disc_r) begin
        if (in_last) begin
          disc_nxt  = 1'b0;
          pos_nxt   = 2'd0;
          accum_nxt = '0;
          pads_nxt  = 2'd0;
        end
      end else if (fail) begin
        q_push       = 1'b1;
        q_job.data   = '0;
        q_job.nbytes = 2'd1;
        q_job.last   = 1'b1;
        q_job.err    = 1'b1;
        q_job.kind   = kind;
        pos_nxt      = 2'd0;
        accum_nxt    = '0;
        pads_nxt     = 2'd0;
        disc_nxt     = !in_last;
      end else if (pos_r != b64d_pkg::POS_LAST) begin
        accum_nxt = {accum_r[11:0], cls.sext};
        pads_nxt  = pads_sum;
        pos_nxt   = pos_r + 2'd1;
      end else begin
        q_push       = 1'b1;
        q_job.data   = {accum_r, cls.sext};
        q_job.nbytes = 2'd3 - pads_sum;
        q_job.last   = in_last;
        q_job.err    = 1'b0;
        q_job.kind   = b64d_pkg::KIND_NONE;
        pos_nxt      = 2'd0;
        accum_nxt    = '0;
        pads_nxt     = 2'd0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r   <= 2'd0;
      accum_r <= '0;
      pads_r  <= 2'd0;
      disc_r  <= 1'b0;
    end else begin
      pos_r   <= pos_nxt;
      accum_r <= accum_nxt;
      pads_r  <= pads_nxt;
      disc_r  <= disc_nxt;
    end
  end

endmodule

// ----- hdl/b64d_queue.sv -----
module b64d_queue (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            push,
  input  b64d_pkg::job_t  push_job,
  output logic            full,
  input  logic            pop,
  output logic            nonempty,
  output b64d_pkg::job_t  head
);

  b64d_pkg::job_t slot_r [b64d_pkg::QDEPTH];

  logic [b64d_pkg::QAW-1:0] wr_r, wr_nxt, rd_r, rd_nxt;
  logic [b64d_pkg::QCW-1:0] cnt_r, cnt_nxt;

  assign full     = (cnt_r == b64d_pkg::QCW'(b64d_pkg::QDEPTH));
  assign nonempty = (cnt_r != '0);
  assign head     = slot_r[rd_r];

  always_comb begin
    wr_nxt  = push ? wr_r + 1'b1 : wr_r;
    rd_nxt  = pop ? rd_r + 1'b1 : rd_r;
    cnt_nxt = cnt_r;
    if (push && !pop) begin
      cnt_nxt = cnt_r + 1'b1;
    end else if (pop && !push) begin
      cnt_nxt = cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      slot_r[wr_r] <= push_job;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_r  <= '0;
      rd_r  <= '0;
      cnt_r <= '0;
    end else begin
      wr_r  <= wr_nxt;
      rd_r  <= rd_nxt;
      cnt_r <= cnt_nxt;
    end
  end

endmodule

// ----- hdl/b64d_back.sv -----
module b64d_back (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            q_nonempty,
  input  b64d_pkg::job_t  q_head,
  output logic            q_pop,
  output logic            out_valid,
  input  logic            out_ready,
  output logic [7:0]      out_byte,
  output logic            out_last,
  output logic            out_error,
  output logic [1:0]      out_error_kind
);

  b64d_pkg::job_t job_r, job_nxt;
  logic           busy_r, busy_nxt;
  logic [1:0]     idx_r, idx_nxt;
  logic           final_beat;

  assign final_beat = (idx_r + 2'd1 == job_r.nbytes);
  assign q_pop      = q_nonempty && (!busy_r || (out_ready && final_beat));

  assign out_valid      = busy_r;
  assign out_last       = job_r.last && final_beat;
  assign out_error      = job_r.err;
  assign out_error_kind = job_r.kind;

  always_comb begin
    case (idx_r)
      2'd0:    out_byte = job_r.data[23:16];
      2'd1:    out_byte = job_r.data[15:8];
      default: out_byte = job_r.data[7:0];
    endcase
  end

  always_comb begin
    job_nxt  = job_r;
    busy_nxt = busy_r;
    idx_nxt  = idx_r;
    if (q_pop) begin
      job_nxt  = q_head;
      busy_nxt = 1'b1;
      idx_nxt  = 2'd0;
    end else if (busy_r && out_ready) begin
      if (final_beat) begin
        busy_nxt = 1'b0;
      end else begin
        idx_nxt = idx_r + 2'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    job_r <= job_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      idx_r  <= 2'd0;
    end else begin
      busy_r <= busy_nxt;
      idx_r  <= idx_nxt;
    end
  end

endmodule

// ----- hdl/base64_stream_decoder_top.sv -----
// Channel  | Direction | Ports                                         | Beat
// ---------+-----------+-----------------------------------------------+---------------------
// input    | in        | in_valid, in_ready, in_char, in_last          | one base64 character
// result   | out       | out_valid, out_ready, out_byte, out_last,     | one byte or one
//          |           | out_error, out_error_kind                     | error report
//
// Takes one character per cycle while in_ready is high; a group of four yields up to three
// bytes, emitted one per cycle by the back end while out_ready is high, so throughput is
// one character/cycle when neither side stalls. A job passes a queue slot and then the
// back-end job register before its first byte appears. The four-entry job queue decouples
// the two ends: in_ready drops only when that queue is full. rst_n is synchronous and
// clears group state, the discard flag, the queue pointers and the output valid.
module base64_stream_decoder_top (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic [7:0] in_char,
  input  logic       in_last,
  output logic       out_valid,
  input  logic       out_ready,
  output logic [7:0] out_byte,
  output logic       out_last,
  output logic       out_error,
  output logic [1:0] out_error_kind
);

  // Front end: classify the character, track the group, build one job per group
  // or per error.
  logic           q_push;
  logic           q_full;
  logic           q_pop;
  logic           q_nonempty;
  b64d_pkg::job_t q_job;
  b64d_pkg::job_t q_head;

  b64d_front u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_char  (in_char),
    .in_last  (in_last),
    .q_full   (q_full),
    .q_push   (q_push),
    .q_job    (q_job)
  );

  // Hold finished jobs so the front keeps accepting while the back drains bytes.
  b64d_queue u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (q_push),
    .push_job (q_job),
    .full     (q_full),
    .pop      (q_pop),
    .nonempty (q_nonempty),
    .head     (q_head)
  );

  // Back end: split each job into one to three result beats.
  b64d_back u_back (
    .clk            (clk),
    .rst_n          (rst_n),
    .q_nonempty     (q_nonempty),
    .q_head         (q_head),
    .q_pop          (q_pop),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .out_byte       (out_byte),
    .out_last       (out_last),
    .out_error      (out_error),
    .out_error_kind (out_error_kind)
  );

endmodule

// ----- hdl/b64d_checker.sv -----
`include "base64_stream_decoder_top_defines.svh"

module b64d_checker (
  input logic       clk,
  input logic       rst_n,
  input logic       out_valid,
  input logic       out_ready,
  input logic [7:0] out_byte,
  input logic       out_last,
  input logic       out_error,
  input logic [1:0] out_error_kind
);

  // An error beat carries a zero byte and a real error kind.
  logic err_shape_ok;

  assign err_shape_ok = (out_byte == 8'd0) && (out_error_kind != b64d_pkg::KIND_NONE);

  `B64D_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(out_byte))
  `B64D_ASSERT_NOW(a_err_last, out_valid && out_error, out_last)
  `B64D_ASSERT_NOW(a_err_body, out_valid && out_error, err_shape_ok)
  `B64D_ASSERT_NOW(a_data_kind, out_valid && !out_error, out_error_kind == b64d_pkg::KIND_NONE)

endmodule

bind base64_stream_decoder_top b64d_checker u_b64d_checker (
  .clk            (clk),
  .rst_n          (rst_n),
  .out_valid      (out_valid),
  .out_ready      (out_ready),
  .out_byte       (out_byte),
  .out_last       (out_last),
  .out_error      (out_error),
  .out_error_kind (out_error_kind)
);

// ----- tb/base64_stream_decoder_checker.sv -----
module base64_stream_decoder_checker (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  input  logic       in_ready,
  input  logic [7:0] in_char,
  input  logic       in_last,
  input  logic       out_valid,
  input  logic       out_ready,
  input  logic [7:0] out_byte,
  input  logic       out_last,
  input  logic       out_error,
  input  logic [1:0] out_error_kind,
  output int         mismatches,
  output int         bytes_pending,
  output int         chars_decoded
);

  localparam int PAD_CODE = 64;
  localparam int BAD_CODE = 65;

  typedef struct packed {
    logic [7:0]           data;
    logic                 last;
    logic                 err;
    b64d_pkg::err_kind_t  kind;
  } decoded_beat_t;

  decoded_beat_t bytes_due[$];

  logic [1:0]  quad_pos;
  logic [17:0] accum;
  logic [1:0]  pad_cnt;
  logic        dropping;
  int          fail_n;
  int          live_n;

  initial begin
    quad_pos      = '0;
    accum         = '0;
    pad_cnt       = '0;
    dropping      = 1'b0;
    fail_n        = 0;
    live_n        = 0;
    mismatches    = 0;
    bytes_pending = 0;
    chars_decoded = 0;
  end

  // 0..63 for a data character, PAD_CODE for '=', BAD_CODE otherwise
  function automatic int sextet_code(input logic [7:0] c);
    if (c >= b64d_pkg::CH_UA && c <= b64d_pkg::CH_UZ) return int'(c - b64d_pkg::CH_UA);
    if (c >= b64d_pkg::CH_LA && c <= b64d_pkg::CH_LZ) return int'(c - b64d_pkg::CH_LA) + 26;
    if (c >= b64d_pkg::CH_D0 && c <= b64d_pkg::CH_D9) return int'(c - b64d_pkg::CH_D0) + 52;
    if (c == b64d_pkg::CH_PLUS) return 62;
    if (c == b64d_pkg::CH_SLASH) return 63;
    if (c == b64d_pkg::CH_PAD) return PAD_CODE;
    return BAD_CODE;
  endfunction

  task automatic clear_group();
    quad_pos = '0;
    accum    = '0;
    pad_cnt  = '0;
  endtask

  // Append one predicted beat at the tail of the queue.
  task automatic expect_beat(input logic [7:0] data, input logic last, input logic err,
                             input b64d_pkg::err_kind_t kind);
    decoded_beat_t beat;
    beat.data = data;
    beat.last = last;
    beat.err  = err;
    beat.kind = kind;
    bytes_due.insert(bytes_due.size(), beat);
  endtask

  task automatic report_error(input b64d_pkg::err_kind_t kind, input logic last);
    expect_beat(8'd0, 1'b1, 1'b1, kind);
    clear_group();
    dropping = !last;
  endtask

  task automatic decode_beat(input logic [7:0] c, input logic last);
    int          code;
    int          pads;
    int          n;
    logic [5:0]  sx;
    logic [23:0] group;
    if (dropping) begin
      if (last) begin
        dropping = 1'b0;
        clear_group();
      end
      return;
    end
    live_n++;
    code = sextet_code(c);
    // length check wins over everything, then alphabet, then padding
    if (last && quad_pos != b64d_pkg::POS_LAST) begin
      report_error(b64d_pkg::KIND_LEN, last);
      return;
    end
    if (code == BAD_CODE) begin
      report_error(b64d_pkg::KIND_BADCH, last);
      return;
    end
    if (code == PAD_CODE) begin
      if (quad_pos < 2 || (quad_pos == b64d_pkg::POS_LAST && !last)) begin
        report_error(b64d_pkg::KIND_PAD, last);
        return;
      end
    end else if (quad_pos == b64d_pkg::POS_LAST && pad_cnt != 0) begin
      report_error(b64d_pkg::KIND_PAD, last);
      return;
    end
    sx   = (code == PAD_CODE) ? 6'd0 : code[5:0];
    pads = int'(pad_cnt) + ((code == PAD_CODE) ? 1 : 0);
    if (quad_pos != b64d_pkg::POS_LAST) begin
      accum    = {accum[11:0], sx};
      pad_cnt  = pads[1:0];
      quad_pos = quad_pos + 2'd1;
      return;
    end
    // trailing bits of the sextet before a pad fall off the emitted bytes
    group = {accum, sx};
    n     = 3 - ((pads > 2) ? 2 : pads);
    for (int i = 0; i < n; i++)
      expect_beat(group[23 - 8 * i -: 8], last && (i == n - 1), 1'b0, b64d_pkg::KIND_NONE);
    clear_group();
  endtask

  always @(posedge clk) begin : watch
    decoded_beat_t want;
    if (!rst_n) begin
      clear_group();
      dropping = 1'b0;
      bytes_due.delete();
    end else begin
      if (in_valid && in_ready)
        decode_beat(in_char, in_last);
      if (out_valid && out_ready) begin
        if (bytes_due.size() == 0) begin
          $error("unexpected result beat: out_byte %0d out_last %0d out_error %0d kind %0d",
                 out_byte, out_last, out_error, out_error_kind);
          fail_n++;
        end else begin
          want = bytes_due.pop_front();
          if (out_byte !== want.data) begin
            $error("out_byte mismatch: expected %0d, got %0d", want.data, out_byte);
            fail_n++;
          end
          if (out_last !== want.last) begin
            $error("out_last mismatch: expected %0d, got %0d", want.last, out_last);
            fail_n++;
          end
          if (out_error !== want.err) begin
            $error("out_error mismatch: expected %0d, got %0d", want.err, out_error);
            fail_n++;
          end
          if (out_error_kind !== want.kind) begin
            $error("out_error_kind mismatch: expected %0d, got %0d", want.kind,
                   out_error_kind);
            fail_n++;
          end
        end
      end
    end
    mismatches    <= fail_n;
    bytes_pending <= bytes_due.size();
    chars_decoded <= live_n;
  end

endmodule

// ----- tb/base64_stream_decoder_top_test.sv -----
// Drive base64 text into the decoder one character per beat, mostly as
// well-formed messages with random payload, plus corrupted, mispadded,
// short, long and noisy messages. The checker beside the block predicts
// every result beat and counts mismatches; this module only makes traffic
// and gives the verdict.
module base64_stream_decoder_top_test;

  localparam int RANDOM_CHARS = 500;
  localparam int CYCLE_LIMIT  = 200000;
  localparam int DRAIN_CYCLES = 8;

  logic       clk = 1'b0;
  logic       rst_n = 1'b0;
  logic       in_valid = 1'b0;
  logic       in_ready;
  logic [7:0] in_char = 8'd0;
  logic       in_last = 1'b0;
  logic       out_valid;
  logic       out_ready = 1'b0;
  logic [7:0] out_byte;
  logic       out_last;
  logic       out_error;
  logic [1:0] out_error_kind;

  int fail_count;
  int bytes_pending;
  int chars_decoded;
  int cycle_count = 0;

  // Steady phases: while set, that side never idles, so back-to-back
  // stretches alternate with heavy gaps.
  bit src_steady = 1'b0;
  bit sink_steady = 1'b0;

  always #10 clk = ~clk;

  base64_stream_decoder_top uut (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .in_char        (in_char),
    .in_last        (in_last),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .out_byte       (out_byte),
    .out_last       (out_last),
    .out_error      (out_error),
    .out_error_kind (out_error_kind)
  );

  base64_stream_decoder_checker decode_check (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .in_char        (in_char),
    .in_last        (in_last),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .out_byte       (out_byte),
    .out_last       (out_last),
    .out_error      (out_error),
    .out_error_kind (out_error_kind),
    .mismatches     (fail_count),
    .bytes_pending  (bytes_pending),
    .chars_decoded  (chars_decoded)
  );

  // Watchdog: a hung handshake or a missing result ends the run here.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("base64_stream_decoder_top test failed");
      $finish;
    end
  end

  function automatic logic [7:0] sextet_char(input logic [5:0] v);
    if (v < 6'd26) return b64d_pkg::CH_UA + v;
    if (v < 6'd52) return b64d_pkg::CH_LA + (v - 6'd26);
    if (v < 6'd62) return b64d_pkg::CH_D0 + (v - 6'd52);
    if (v == 6'd62) return b64d_pkg::CH_PLUS;
    return b64d_pkg::CH_SLASH;
  endfunction

  // Send one character beat. Idle a random number of cycles first, then
  // hold valid and payload until the block takes the beat. A zero gap
  // leaves valid high straight from the previous beat.
  task automatic send_char(input logic [7:0] c, input logic last);
    int gap;
    gap = src_steady ? 0 : $urandom_range(0, 13);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_char  <= c;
    in_last  <= last;
    do @(posedge clk); while (!in_ready);
  endtask

  task automatic send_text(input string s, input logic last_at_end);
    for (int i = 0; i < s.len(); i++)
      send_char(s[i], last_at_end && (i == s.len() - 1));
  endtask

  // Result side: stall a random number of cycles before each beat, then
  // hold ready until a beat goes through.
  initial begin : sink
    int stall;
    do @(posedge clk); while (!rst_n);
    forever begin
      if ($urandom_range(0, 29) == 0) sink_steady = ~sink_steady;
      stall = sink_steady ? 0 : $urandom_range(0, 13);
      if (stall > 0) begin
        out_ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      out_ready <= 1'b1;
      do @(posedge clk); while (!out_valid);
    end
  end

  initial begin : stimulus
    logic [8:0]  msg[$];   // {last, character}
    logic [23:0] word;
    int          nbytes;
    int          rest;
    int          roll;
    int          spot;
    int          base;

    repeat (10) @(posedge clk);
    rst_n <= 1'b1;

    // Directed: plain groups covering the alphabet edges, one and two pads
    // (the latter with nonzero trailing bits), then each error kind.
    send_text("TWFu", 1'b1);
    send_text("AZaz", 1'b0);
    send_text("+/09", 1'b1);
    send_text("QR==", 1'b1);
    send_text("QUI=", 1'b1);
    send_text("AB", 1'b1);       // short message: wrong length
    send_text("*A", 1'b1);       // bad character, then drop to the last beat
    send_text("=", 1'b0);        // pad in the first slot of a group
    send_text("x", 1'b1);

    // Random messages until enough characters were actually decoded.
    base = chars_decoded;
    while (chars_decoded - base < RANDOM_CHARS) begin
      if ($urandom_range(0, 11) == 0) src_steady = ~src_steady;

      // Mostly short payloads, a few long ones.
      nbytes = ($urandom_range(0, 9) == 0) ? $urandom_range(10, 30) : $urandom_range(1, 6);
      msg.delete();
      for (int i = 0; i < nbytes; i += 3) begin
        // bytes past the payload end only feed trailing bits, which must drop
        word = 24'($urandom);
        rest = nbytes - i;
        msg.insert(msg.size(), {1'b0, sextet_char(word[23:18])});
        msg.insert(msg.size(), {1'b0, sextet_char(word[17:12])});
        msg.insert(msg.size(),
                   {1'b0, (rest > 1) ? sextet_char(word[11:6]) : b64d_pkg::CH_PAD});
        msg.insert(msg.size(),
                   {1'b0, (rest > 2) ? sextet_char(word[5:0]) : b64d_pkg::CH_PAD});
      end
      msg[msg.size() - 1][8] = 1'b1;

      // Break about a third of the messages.
      roll = $urandom_range(0, 99);
      spot = $urandom_range(0, msg.size() - 1);
      if (roll >= 70) begin
        if (roll < 78) begin
          msg[spot][7:0] = 8'($urandom);
        end else if (roll < 86) begin
          msg[spot][7:0] = b64d_pkg::CH_PAD;
        end else if (roll < 92) begin
          if ($urandom_range(0, 1)) begin
            void'(msg.pop_back());
            msg[msg.size() - 1][8] = 1'b1;
          end else begin
            msg[msg.size() - 1][8] = 1'b0;
            msg.insert(msg.size(), {1'b1, sextet_char(6'($urandom))});
          end
        end else if (roll < 96) begin
          msg[spot][8] = 1'b1;
        end else begin
          // pure noise over the whole byte range, with stray last marks
          msg.delete();
          repeat ($urandom_range(1, 8))
            msg.insert(msg.size(), {($urandom_range(0, 3) == 0), 8'($urandom)});
          msg[msg.size() - 1][8] = 1'b1;
        end
      end

      foreach (msg[k]) send_char(msg[k][7:0], msg[k][8]);
    end

    // Drain: drop valid, wait for every predicted beat, then a few more
    // cycles so a stray extra beat still shows up.
    in_valid <= 1'b0;
    do @(posedge clk); while (bytes_pending != 0);
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (fail_count == 0) begin
      $display("base64_stream_decoder_top test passed");
    end else begin
      $display("base64_stream_decoder_top test failed");
    end
    $finish;
  end

endmodule
